@@ rtl/bcdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub package
// Operation codes, controller states and the command group shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdsm_pkg;

	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] RADIX     = 5'd10;

	typedef enum logic [2:0] {
		MODE_LOAD = 3'd0,
		MODE_ADD  = 3'd1,
		MODE_SUB  = 3'd2,
		MODE_CMP  = 3'd3,
		MODE_NEG  = 3'd4,
		MODE_ABS  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CMP   = 2'd1,
		ST_ARITH = 2'd2,
		ST_OUT   = 2'd3
	} state_t;

	typedef struct packed {
		logic shift_in;
		logic begin_op;
		logic cmp_step;
		logic arith_step;
		logic arith_last;
		logic out_step;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/bcd_sign_magnitude_add_sub_core.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub core
// Signed decimal accumulator: loads, adds, subtracts, compares, negates or
// takes the absolute value against an operand entered one digit at a time.
//
//   Channel   Handshake             Payload
//   operand   start / busy          mode, digit, operand_negative, operand_last
//   result    result_strobe         result_digit, result_negative, overflow,
//                                   was_less, was_equal, is_zero, run_last
//
// A digit without operand_last is shifted in and busy stays low.
// The final digit starts a sequence in which one serial digit unit makes
// a compare pass, an add/subtract pass and an output pass over the ring.
// Results appear during the output pass, one per cycle.
// Results cannot be stalled; busy holds off new operand digits meanwhile.
// arst_n clears the accumulator to +0 and the operand register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_sign_magnitude_add_sub_core import bcdsm_pkg::*; #(
	parameter int unsigned NUM_DIGITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [3:0] digit,
	input  logic       operand_negative,
	input  logic       operand_last,
	output logic       result_strobe,
	output logic [3:0] result_digit,
	output logic       result_negative,
	output logic       overflow,
	output logic       was_less,
	output logic       was_equal,
	output logic       is_zero,
	output logic       run_last
);

	cmd_t cmd;

	bcdsm_ctrl #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operand_last (operand_last),
		.busy         (busy),
		.result_strobe(result_strobe),
		.run_last     (run_last),
		.cmd          (cmd)
	);

	bcdsm_datapath #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.mode            (mode),
		.digit           (digit),
		.operand_negative(operand_negative),
		.result_digit    (result_digit),
		.result_negative (result_negative),
		.overflow        (overflow),
		.was_less        (was_less),
		.was_equal       (was_equal),
		.is_zero         (is_zero)
	);

endmodule

`default_nettype wire

@@ rtl/bcdsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub controller
// Sequences the compare, arithmetic and output passes over the digits.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsm_ctrl import bcdsm_pkg::*; #(
	parameter int unsigned NUM_DIGITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic operand_last,
	output logic busy,
	output logic result_strobe,
	output logic run_last,
	output cmd_t cmd
);

	localparam int unsigned STEP_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              step_end;

	assign step_end = (step_q == STEP_W'(NUM_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || step_end) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && operand_last) state_d = ST_CMP;
			end
			ST_CMP: begin
				if (step_end) state_d = ST_ARITH;
			end
			ST_ARITH: begin
				if (step_end) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (step_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		busy          = 1'b1;
		result_strobe = 1'b0;
		run_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.shift_in  = start;
				cmd.begin_op  = start && operand_last;
			end
			ST_CMP: begin
				cmd.cmp_step = 1'b1;
			end
			ST_ARITH: begin
				cmd.arith_step = 1'b1;
				cmd.arith_last = step_end;
			end
			ST_OUT: begin
				cmd.out_step  = 1'b1;
				result_strobe = 1'b1;
				run_last      = step_end;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bcdsm_datapath.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub datapath
// Operand and accumulator digit rings with one digit-serial compare and
// add/subtract unit, plus the sign and flag registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsm_datapath import bcdsm_pkg::*; #(
	parameter int unsigned NUM_DIGITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [2:0] mode,
	input  logic [3:0] digit,
	input  logic       operand_negative,
	output logic [3:0] result_digit,
	output logic       result_negative,
	output logic       overflow,
	output logic       was_less,
	output logic       was_equal,
	output logic       is_zero
);

	localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);

	// Index 0 holds the most significant digit.
	logic [NUM_DIGITS-1:0][3:0] acc_q;
	logic [NUM_DIGITS-1:0][3:0] op_q;
	logic [NUM_DIGITS-1:0][3:0] acc_rotl;
	logic [NUM_DIGITS-1:0][3:0] acc_rotr;
	logic [NUM_DIGITS-1:0][3:0] op_rotl;
	logic [NUM_DIGITS-1:0][3:0] op_rotr;
	logic [NUM_DIGITS-1:0][3:0] op_shin;

	logic             sign_q;
	logic             bad_q;
	logic [CNT_W-1:0] cnt_q;
	mode_t            mode_q;
	logic             opneg_q;
	logic             mag_eq_q;
	logic             mag_lt_q;
	logic             carry_q;
	logic             zero_q;
	logic             ovf_q;
	logic             less_q;
	logic             equal_q;

	logic       digit_bad;
	logic [3:0] digit_eff;
	logic [3:0] a_msd;
	logic [3:0] b_msd;
	logic [3:0] a_lsd;
	logic [3:0] b_lsd;
	logic       sb;
	logic       sb_eff;
	logic       same;
	logic       addsub;
	logic [4:0] sum;
	logic [3:0] sum_d;
	logic       c_add;
	logic [3:0] top;
	logic [4:0] bot;
	logic [3:0] diff;
	logic       borrow;
	logic       carry_next;
	logic [3:0] r_digit;
	logic       force_mz;
	logic       new_sign;
	logic       less_c;
	logic       equal_c;

	assign digit_bad = (digit > DIGIT_MAX);
	assign digit_eff = digit_bad ? 4'd0 : digit;

	genvar g;
	generate
		for (g = 0; g < NUM_DIGITS; g++) begin : g_ring
			if (g == NUM_DIGITS - 1) begin : g_low
				assign acc_rotl[g] = acc_q[0];
				assign op_rotl[g]  = op_q[0];
				assign op_shin[g]  = digit_eff;
			end else begin : g_mid
				assign acc_rotl[g] = acc_q[g+1];
				assign op_rotl[g]  = op_q[g+1];
				assign op_shin[g]  = op_q[g+1];
			end
			if (g == 0) begin : g_high
				assign acc_rotr[g] = r_digit;
				assign op_rotr[g]  = op_q[NUM_DIGITS-1];
			end else begin : g_rest
				assign acc_rotr[g] = acc_q[g-1];
				assign op_rotr[g]  = op_q[g-1];
			end
		end
	endgenerate

	// A bad operand reads as minus zero everywhere.
	assign a_msd  = acc_q[0];
	assign b_msd  = bad_q ? 4'd0 : op_q[0];
	assign a_lsd  = acc_q[NUM_DIGITS-1];
	assign b_lsd  = bad_q ? 4'd0 : op_q[NUM_DIGITS-1];
	assign sb     = bad_q | opneg_q;
	assign sb_eff = (mode_q == MODE_SUB) ? !sb : sb;
	assign same   = (sign_q == sb_eff);
	assign addsub = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);

	always_comb begin
		sum   = {1'b0, a_lsd} + {1'b0, b_lsd} + {4'd0, carry_q};
		c_add = (sum > {1'b0, DIGIT_MAX});
		sum_d = c_add ? 4'(sum - RADIX) : sum[3:0];

		// Mixed effective signs: larger magnitude minus smaller.
		top    = mag_lt_q ? b_lsd : a_lsd;
		bot    = (mag_lt_q ? {1'b0, a_lsd} : {1'b0, b_lsd}) + {4'd0, carry_q};
		borrow = ({1'b0, top} < bot);
		diff   = borrow ? 4'({1'b0, top} + RADIX - bot) : 4'({1'b0, top} - bot);

		carry_next = addsub && (same ? c_add : borrow);

		case (mode_q) inside
			MODE_LOAD: r_digit = b_lsd;
			MODE_ADD, MODE_SUB: begin
				if (same) begin
					r_digit = sum_d;
				end else if (mag_eq_q) begin
					r_digit = 4'd0;
				end else begin
					r_digit = diff;
				end
			end
			default: r_digit = a_lsd;
		endcase

		case (mode_q) inside
			MODE_LOAD: new_sign = sb;
			MODE_ADD, MODE_SUB: begin
				if (same) begin
					new_sign = sign_q;
				end else if (mag_eq_q) begin
					new_sign = 1'b0;
				end else begin
					new_sign = mag_lt_q ? !sign_q : sign_q;
				end
			end
			MODE_NEG: new_sign = !sign_q;
			MODE_ABS: new_sign = 1'b0;
			default:  new_sign = sign_q;
		endcase

		force_mz = bad_q || (addsub && same && c_add);

		equal_c = (sign_q == sb) && mag_eq_q;
		if (sign_q != sb) begin
			less_c = sign_q;
		end else if (mag_eq_q) begin
			less_c = 1'b0;
		end else begin
			less_c = sign_q ? !mag_lt_q : mag_lt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			op_q     <= '0;
			sign_q   <= 1'b0;
			bad_q    <= 1'b0;
			cnt_q    <= '0;
			mode_q   <= MODE_LOAD;
			opneg_q  <= 1'b0;
			mag_eq_q <= 1'b1;
			mag_lt_q <= 1'b0;
			carry_q  <= 1'b0;
			zero_q   <= 1'b1;
			ovf_q    <= 1'b0;
			less_q   <= 1'b0;
			equal_q  <= 1'b0;
		end else begin
			if (cmd.shift_in) begin
				if (digit_bad || (cnt_q >= CNT_W'(NUM_DIGITS))) bad_q <= 1'b1;
				if (cnt_q < CNT_W'(NUM_DIGITS)) begin
					op_q  <= op_shin;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.begin_op) begin
				mode_q   <= mode_t'(mode);
				opneg_q  <= operand_negative;
				mag_eq_q <= 1'b1;
				mag_lt_q <= 1'b0;
				carry_q  <= 1'b0;
				zero_q   <= 1'b1;
			end
			if (cmd.cmp_step) begin
				acc_q <= acc_rotl;
				op_q  <= op_rotl;
				// The first differing digit from the top decides the order.
				if (mag_eq_q && (a_msd != b_msd)) begin
					mag_eq_q <= 1'b0;
					mag_lt_q <= (a_msd < b_msd);
				end
			end
			if (cmd.arith_step) begin
				carry_q <= carry_next;
				if (cmd.arith_last) begin
					less_q  <= less_c;
					equal_q <= equal_c;
					ovf_q   <= force_mz;
					sign_q  <= force_mz ? 1'b1 : new_sign;
					acc_q   <= force_mz ? '0 : acc_rotr;
					zero_q  <= force_mz || (zero_q && (r_digit == 4'd0));
					op_q    <= '0;
					bad_q   <= 1'b0;
					cnt_q   <= '0;
				end else begin
					acc_q  <= acc_rotr;
					op_q   <= op_rotr;
					zero_q <= zero_q && (r_digit == 4'd0);
				end
			end
			if (cmd.out_step) begin
				acc_q <= acc_rotl;
			end
		end
	end

	assign result_digit    = acc_q[0];
	assign result_negative = sign_q;
	assign overflow        = ovf_q;
	assign was_less        = less_q;
	assign was_equal       = equal_q;
	assign is_zero         = zero_q;

endmodule

`default_nettype wire

@@ rtl/bcdsm_checker.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub port checker
// Watches the core's ports for result, overflow and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdsm_checker import bcdsm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       operand_last,
	input logic       result_strobe,
	input logic [3:0] result_digit,
	input logic       result_negative,
	input logic       overflow,
	input logic       is_zero,
	input logic       run_last
);

	// Results are only delivered while the core refuses new digits.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result transfer while not busy");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		run_last |-> result_strobe)
		else $error("run_last without a result transfer");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result_digit <= DIGIT_MAX))
		else $error("result digit is not a decimal digit");

	// An overflowed accumulator is always minus zero.
	a_ovf_mzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && overflow) |-> (result_negative && is_zero))
		else $error("overflow result is not minus zero");

	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operand_last) |=> busy)
		else $error("final digit did not start an operation");

endmodule

bind bcd_sign_magnitude_add_sub_core bcdsm_checker u_bcdsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.operand_last   (operand_last),
	.result_strobe  (result_strobe),
	.result_digit   (result_digit),
	.result_negative(result_negative),
	.overflow       (overflow),
	.is_zero        (is_zero),
	.run_last       (run_last)
);

`default_nettype wire

@@ dv/bcd_sign_magnitude_add_sub_core_tb.sv @@
// ----------------------------------------------------------------------------
// BCD sign-magnitude add/sub core testbench
// Operand digits are queued up front and fed to the core by a clocked driver
// with random gaps. Each accepted last digit is run through a digit-level
// model of the accumulator, and the resulting digit stream is checked field
// by field against what the core emits.
// ----------------------------------------------------------------------------
module bcd_sign_magnitude_add_sub_core_tb import bcdsm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_DIGITS   = 32;
	localparam int unsigned CLK_PERIOD   = 20;
	localparam int unsigned TARGET_ITEMS = 370;
	localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

	// Mode codes that the package leaves unnamed; the core treats them as compare.
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	// Index 0 is the least significant digit.
	typedef logic [NUM_DIGITS-1:0][3:0] bcd_mag_t;

	typedef struct {
		logic [2:0]  mode;
		logic [3:0]  digit;
		logic        neg;
		logic        last;
		int unsigned gap;
		bit          drain;
	} op_item_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       neg;
		logic       ovf;
		logic       less;
		logic       equal;
		logic       zero;
		logic       last;
	} digit_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] mode = 3'd0;
	logic [3:0] digit = 4'd0;
	logic       operand_negative = 1'b0;
	logic       operand_last = 1'b0;
	logic       result_strobe;
	logic [3:0] result_digit;
	logic       result_negative;
	logic       overflow;
	logic       was_less;
	logic       was_equal;
	logic       is_zero;
	logic       run_last;

	op_item_t      item_q [$];
	digit_result_t digit_stream_q [$];
	int unsigned   items_queued = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   results_predicted = 0;
	int unsigned   results_checked = 0;

	// Model of the accumulator and the operand shift register.
	bcd_mag_t    acc_mag = '0;
	logic        acc_neg = 1'b0;
	bcd_mag_t    opnd_mag = '0;
	logic        opnd_bad = 1'b0;
	int unsigned opnd_count = 0;

	// Driver bookkeeping.
	op_item_t    cur;
	op_item_t    nxt;
	bit          staged = 1'b0;
	int unsigned gap_left = 0;

	bcd_sign_magnitude_add_sub_core #(.NUM_DIGITS(NUM_DIGITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.digit(digit),
		.operand_negative(operand_negative),
		.operand_last(operand_last),
		.result_strobe(result_strobe),
		.result_digit(result_digit),
		.result_negative(result_negative),
		.overflow(overflow),
		.was_less(was_less),
		.was_equal(was_equal),
		.is_zero(is_zero),
		.run_last(run_last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("%0t ns ERROR: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	function automatic bcd_mag_t bcd_add(input bcd_mag_t a, input bcd_mag_t b,
			output logic carry);
		logic [4:0] sum;
		bcd_mag_t   r;
		carry = 1'b0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			sum = a[i] + b[i] + carry;
			if (sum > DIGIT_MAX) begin
				r[i] = 4'(sum - RADIX);
				carry = 1'b1;
			end else begin
				r[i] = sum[3:0];
				carry = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic bcd_mag_t bcd_sub(input bcd_mag_t big, input bcd_mag_t lesser);
		logic [4:0] top;
		logic [4:0] bot;
		logic       borrow;
		bcd_mag_t   r;
		borrow = 1'b0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			top = big[i];
			bot = lesser[i] + borrow;
			if (top < bot) begin
				r[i] = 4'(top + RADIX - bot);
				borrow = 1'b1;
			end else begin
				r[i] = 4'(top - bot);
				borrow = 1'b0;
			end
		end
		return r;
	endfunction

	// Shifts one operand digit in; on the last digit applies the mode and queues
	// the full digit stream of the new accumulator.
	task automatic accumulate_digit(input op_item_t it);
		logic [3:0]    d;
		bcd_mag_t      opm;
		bcd_mag_t      new_mag;
		logic          op_n;
		logic          new_neg;
		logic          ovf;
		logic          less;
		logic          equal;
		logic          carry;
		logic          zero;
		digit_result_t r;
		d = it.digit;
		if (d > DIGIT_MAX) begin
			opnd_bad = 1'b1;
			d = 4'd0;
		end
		if (opnd_count >= NUM_DIGITS) begin
			opnd_bad = 1'b1;
		end else begin
			opnd_mag = {opnd_mag[NUM_DIGITS-2:0], d};
			opnd_count++;
		end
		if (!it.last) return;

		if (opnd_bad) begin
			opm = '0;
			op_n = 1'b1;
		end else begin
			opm = opnd_mag;
			op_n = it.neg;
		end

		equal = (acc_neg == op_n) && (acc_mag == opm);
		if (acc_neg != op_n) begin
			less = acc_neg;
		end else if (acc_mag == opm) begin
			less = 1'b0;
		end else begin
			less = acc_neg ? (acc_mag > opm) : (acc_mag < opm);
		end

		new_mag = acc_mag;
		new_neg = acc_neg;
		ovf = 1'b0;
		case (it.mode) inside
			MODE_LOAD: begin
				new_mag = opm;
				new_neg = op_n;
			end
			MODE_ADD, MODE_SUB: begin
				// Magnitudes add for a same-sign add or a mixed-sign subtract;
				// otherwise the smaller magnitude comes off the larger.
				if ((it.mode == MODE_ADD) == (acc_neg == op_n)) begin
					new_mag = bcd_add(acc_mag, opm, carry);
					if (carry) begin
						new_mag = '0;
						new_neg = 1'b1;
						ovf = 1'b1;
					end
				end else if (acc_mag == opm) begin
					new_mag = '0;
					new_neg = 1'b0;
				end else if (opm < acc_mag) begin
					new_mag = bcd_sub(acc_mag, opm);
				end else begin
					new_mag = bcd_sub(opm, acc_mag);
					new_neg = !acc_neg;
				end
			end
			MODE_NEG: begin
				new_neg = !acc_neg;
			end
			MODE_ABS: begin
				new_neg = 1'b0;
			end
			default: begin
			end
		endcase
		if (opnd_bad) begin
			new_mag = '0;
			new_neg = 1'b1;
			ovf = 1'b1;
		end

		acc_mag = new_mag;
		acc_neg = new_neg;
		opnd_mag = '0;
		opnd_bad = 1'b0;
		opnd_count = 0;
		zero = (new_mag == '0);

		for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
			r.digit = new_mag[k];
			r.neg = new_neg;
			r.ovf = ovf;
			r.less = less;
			r.equal = equal;
			r.zero = zero;
			r.last = (k == 0);
			digit_stream_q.push_back(r);
		end
	endtask

	task automatic queue_digits(input logic [2:0] m, input logic n, input logic [3:0] digs [$],
			input bit no_idle, input bit drain);
		op_item_t it;
		foreach (digs[i]) begin
			it.last = (i == digs.size() - 1);
			// Mode and sign only matter on the last digit; elsewhere they are noise.
			it.mode = it.last ? m : 3'($urandom_range(0, 7));
			it.neg = it.last ? n : 1'($urandom_range(0, 1));
			it.digit = digs[i];
			it.gap = no_idle ? 0 : $urandom_range(0, 9);
			it.drain = drain && (i == 0);
			item_q.push_back(it);
		end
		items_queued += digs.size();
	endtask

	// Digits are given as a hex string, most significant first.
	task automatic queue_str(input logic [2:0] m, input logic n, input string s);
		logic [3:0] digs [$];
		for (int i = 0; i < s.len(); i++) begin
			digs.push_back((s[i] >= "a") ? 4'(s[i] - "a" + 10) : 4'(s[i] - "0"));
		end
		queue_digits(m, n, digs, 1'b0, 1'b0);
	endtask

	always @(posedge clk) begin : driver_proc
		logic accepted;
		logic hold;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) begin
				accumulate_digit(cur);
				if (cur.last) begin
					results_predicted <= results_predicted + NUM_DIGITS;
				end
			end
			if (accepted || !start) begin
				if (!staged && item_q.size() != 0) begin
					nxt = item_q.pop_front();
					staged = 1'b1;
					gap_left = nxt.gap;
				end
				hold = nxt.drain && ((accepted && cur.last) ||
					(results_predicted != results_checked));
				if (staged && gap_left == 0 && !hold) begin
					cur = nxt;
					staged = 1'b0;
					start <= 1'b1;
					mode <= cur.mode;
					digit <= cur.digit;
					operand_negative <= cur.neg;
					operand_last <= cur.last;
				end else begin
					if (staged && gap_left != 0) gap_left--;
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor_proc
		digit_result_t want;
		if (arst_n && result_strobe) begin
			if (digit_stream_q.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = digit_stream_q.pop_front();
				check_field("result_digit", result_digit, want.digit);
				check_field("result_negative", result_negative, want.neg);
				check_field("overflow", overflow, want.ovf);
				check_field("was_less", was_less, want.less);
				check_field("was_equal", was_equal, want.equal);
				check_field("is_zero", is_zero, want.zero);
				check_field("run_last", run_last, want.last);
			end
			results_checked <= results_checked + 1;
		end
	end

	initial begin : stimulus
		logic [3:0]  digs [$];
		logic [2:0]  m;
		int unsigned kind;
		int unsigned len;
		int unsigned op_idx;
		bit          nines;
		bit          no_idle;

		// Directed: sign handling, equal operands, unused modes, overflow, bad digits.
		queue_str(MODE_LOAD, 1'b0, "7");
		queue_str(MODE_CMP, 1'b0, "07");
		queue_str(MODE_ADD, 1'b1, "12");
		queue_str(MODE_SUB, 1'b1, "5");
		queue_str(MODE_SUB, 1'b0, "3");
		queue_str(MODE_NEG, 1'b1, "4");
		queue_str(MODE_LOAD, 1'b1, "8");
		queue_str(MODE_ABS, 1'b0, "0");
		queue_str(MODE_SPARE_6, 1'b1, "1");
		queue_str(MODE_SPARE_7, 1'b0, "2");
		queue_str(MODE_LOAD, 1'b0, "99999999999999999999999999999999");
		queue_str(MODE_ADD, 1'b0, "1");
		queue_str(MODE_ADD, 1'b0, "f");
		queue_str(MODE_LOAD, 1'b1, "a5");
		queue_str(MODE_SUB, 1'b1, "0");

		// Random: mostly well-formed operands, some full length, some broken.
		op_idx = 0;
		no_idle = 1'b0;
		while (items_queued < TARGET_ITEMS) begin
			if (op_idx % 8 == 0) no_idle = ($urandom_range(0, 2) == 0);
			digs.delete();
			kind = $urandom_range(0, 99);
			if (kind < 70) len = $urandom_range(1, 6);
			else if (kind < 84) len = NUM_DIGITS;
			else if (kind < 94) len = $urandom_range(1, 8);
			else len = $urandom_range(NUM_DIGITS + 1, NUM_DIGITS + 3);
			nines = (kind >= 70) && (kind < 84) && ($urandom_range(0, 1) == 1);
			for (int j = 0; j < len; j++) begin
				digs.push_back(nines ? DIGIT_MAX : 4'($urandom_range(0, 9)));
			end
			if (kind >= 84 && kind < 94) begin
				digs[$urandom_range(0, len - 1)] = 4'($urandom_range(10, 15));
			end
			m = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 5)) :
				3'($urandom_range(6, 7));
			queue_digits(m, 1'($urandom_range(0, 1)), digs, no_idle,
				(op_idx == 0) || (op_idx == 25));
			op_idx++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (item_q.size() != 0 || staged || start) @(negedge clk);
		for (int c = 0; c < 4 * NUM_DIGITS + 20 && digit_stream_q.size() != 0; c++) begin
			@(negedge clk);
		end
		repeat (3 * NUM_DIGITS + 10) @(negedge clk);
		if (digit_stream_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				digit_stream_q.size()));
		end

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bcdsm_pkg.sv
rtl/bcdsm_ctrl.sv
rtl/bcdsm_datapath.sv
rtl/bcd_sign_magnitude_add_sub_core.sv
rtl/bcdsm_checker.sv
dv/bcd_sign_magnitude_add_sub_core_tb.sv
